>>> rtl/pcg32_pkg.sv
// ----------------------------------------------------------------------------
// pcg32_pkg
// Shared constants, types and controller-to-datapath signal groups of the
// pcg32 xsh-rr generator.
// ----------------------------------------------------------------------------
package pcg32_pkg;

  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SEED_W    = 64;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned HALF_W    = 32;

  localparam logic [CNT_W-1:0]  MAX_COUNT     = 7'd64;
  localparam logic [SEED_W-1:0] PCG_MULT      = 64'd6364136223846793005;
  localparam logic [SEED_W-1:0] PCG_DEF_STATE = 64'h853c49e6748fea9b;
  localparam logic [SEED_W-1:0] PCG_DEF_INC   = 64'hda3e39cb94b95bdb;

  localparam int unsigned XS_SHIFT  = 18;
  localparam int unsigned XS_DROP   = 27;
  localparam int unsigned ROT_POS   = 59;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEED = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DRAW = 4'b1000
  } pcg_state_t;

  // steps of the 64-bit lcg advance on one shared 32x32 multiplier
  typedef enum logic [1:0] {
    MUL_LO   = 2'd0,
    MUL_X1   = 2'd1,
    MUL_X2   = 2'd2,
    MUL_DONE = 2'd3
  } mul_step_t;

  typedef struct packed {
    logic      load_seed;
    logic      mul_en;
    mul_step_t mul_step;
    logic      draw;
    logic      draw_last;
  } pcg_cmd_t;

  typedef struct packed {
    logic seed_written;
  } pcg_status_t;

endpackage

>>> rtl/pcg32_if.sv
// ----------------------------------------------------------------------------
// pcg32 channel interfaces
// Valid/ready channels for requests, results and seed writes.
// ----------------------------------------------------------------------------
interface pcg32_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] count;
  modport source (output valid, output count, input ready);
  modport sink   (input valid, input count, output ready);
endinterface

interface pcg32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface pcg32_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] stream_seed;
  modport source (output valid, output stream_seed, input ready);
  modport sink   (input valid, input stream_seed, output ready);
endinterface

>>> rtl/pcg32_ctrl.sv
// ----------------------------------------------------------------------------
// pcg32_ctrl
// Request sequencer: seeding, lcg advance steps, draws and the output
// register's valid flag.
// ----------------------------------------------------------------------------
module pcg32_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pcg32_pkg::CNT_W-1:0] in_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  pcg32_pkg::pcg_status_t     status,
  output pcg32_pkg::pcg_cmd_t        cmd
);
  import pcg32_pkg::*;

  pcg_state_t       state_r, state_nxt;
  mul_step_t        step_r, step_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             seeded_r, seeded_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] req_cnt;
  logic             slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign req_cnt   = (in_count > MAX_COUNT) ? MAX_COUNT : in_count;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    left_nxt      = left_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_step  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          left_nxt = req_cnt;
          if (!seeded_r) begin
            state_nxt = ST_SEED;
          end else if (req_cnt != '0) begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        cmd.load_seed = 1'b1;
        seeded_nxt    = 1'b1;
        step_nxt      = MUL_LO;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        unique case (step_r)
          MUL_LO:   step_nxt = MUL_X1;
          MUL_X1:   step_nxt = MUL_X2;
          MUL_X2:   step_nxt = MUL_DONE;
          MUL_DONE: begin
            step_nxt  = MUL_LO;
            state_nxt = (left_r == '0) ? ST_IDLE : ST_DRAW;
          end
          default:  step_nxt = MUL_LO;
        endcase
      end
      ST_DRAW: begin
        if (slot_free) begin
          cmd.draw      = 1'b1;
          cmd.draw_last = (left_r == CNT_W'(1));
          left_nxt      = left_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          step_nxt      = MUL_LO;
          state_nxt     = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a new seed forces reseeding on the next request
    if (status.seed_written) begin
      seeded_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= MUL_LO;
      left_r      <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      left_r      <= left_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/pcg32_dpath.sv
// ----------------------------------------------------------------------------
// pcg32_dpath
// Seed, stream increment and lcg state registers, shared 32x32 multiplier
// for the lcg advance, xsh-rr output function and result register.
// ----------------------------------------------------------------------------
module pcg32_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcg32_pkg::SEED_W-1:0]  cfg_stream_seed,
  input  pcg32_pkg::pcg_cmd_t           cmd,
  output pcg32_pkg::pcg_status_t        status,
  output logic [pcg32_pkg::VALUE_W-1:0] out_value,
  output logic                          out_last
);
  import pcg32_pkg::*;

  localparam logic [HALF_W-1:0] MULT_LO = PCG_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MULT_HI = PCG_MULT[SEED_W-1:HALF_W];

  logic [SEED_W-1:0]  seed_r;
  logic [SEED_W-1:0]  lcg_r;
  logic [SEED_W-1:0]  inc_r;
  logic [SEED_W-1:0]  prod_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;

  logic [SEED_W-1:0]  ist;
  logic [SEED_W-1:0]  sq;
  logic [SEED_W-1:0]  inc_seed;
  logic [HALF_W-1:0]  mul_a;
  logic [HALF_W-1:0]  mul_b;
  logic [SEED_W-1:0]  mul_p;
  logic [VALUE_W-1:0] xs;
  logic [4:0]         rot;
  logic [2*VALUE_W-1:0] xs_rot;
  logic               cfg_fire;

  assign cfg_ready           = 1'b1;
  assign cfg_fire            = cfg_valid && cfg_ready;
  assign status.seed_written = cfg_fire;

  // seeding: zero start state or zero seed fall back to the defaults
  always_comb begin
    ist = PCG_DEF_STATE ^ seed_r;
    if (ist == '0) begin
      ist = PCG_DEF_STATE;
    end
    sq = (seed_r == '0) ? PCG_DEF_INC : seed_r;
    inc_seed = {sq[SEED_W-2:0], 1'b1};
  end

  // low word of s*m plus the two cross terms folded into the high word
  assign mul_a = (cmd.mul_step == MUL_X2) ? lcg_r[SEED_W-1:HALF_W] : lcg_r[HALF_W-1:0];
  assign mul_b = (cmd.mul_step == MUL_X1) ? MULT_HI : MULT_LO;
  assign mul_p = SEED_W'(mul_a) * SEED_W'(mul_b);

  // xsh-rr output function
  assign xs     = VALUE_W'(((lcg_r >> XS_SHIFT) ^ lcg_r) >> XS_DROP);
  assign rot    = lcg_r[ROT_POS+4:ROT_POS];
  assign xs_rot = {xs, xs} >> rot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      lcg_r  <= '0;
      inc_r  <= '0;
    end else begin
      if (cfg_fire) begin
        seed_r <= cfg_stream_seed;
      end
      if (cmd.load_seed) begin
        inc_r <= inc_seed;
        lcg_r <= inc_seed + ist;
      end else if (cmd.mul_en && cmd.mul_step == MUL_DONE) begin
        lcg_r <= prod_r + inc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_step)
        MUL_LO:   prod_r <= mul_p;
        MUL_X1,
        MUL_X2:   prod_r[SEED_W-1:HALF_W] <= prod_r[SEED_W-1:HALF_W] + mul_p[HALF_W-1:0];
        MUL_DONE: prod_r <= prod_r;
        default:  prod_r <= prod_r;
      endcase
    end
    if (cmd.draw) begin
      value_r <= xs_rot[VALUE_W-1:0];
      last_r  <= cmd.draw_last;
    end
  end

  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

>>> rtl/pcg32_random_generator_top.sv
// ----------------------------------------------------------------------------
// pcg32_random_generator_top
// PCG32 xsh-rr generator returning a requested count of 32-bit numbers.
// ----------------------------------------------------------------------------
// A request carries a count of 1 to 64 numbers (larger counts give 64, zero
// gives none) and returns that many results, the final one flagged by last.
// Each lcg advance runs on one shared 32x32 multiplier in steps (low
// product, two cross terms, increment add). Every number is first drawn
// into the output register, which waits while that register still holds
// an unaccepted result, and then the state is advanced. A request must
// reseed first when a new seed has been written. New requests are taken
// only once the previous one has finished; the seed port is always ready
// and should be written only while idle.
module pcg32_random_generator_top (
  input  logic               clk,
  input  logic               rst_n,
  pcg32_in_if.sink           in_chan,
  pcg32_out_if.source        out_chan,
  pcg32_cfg_if.sink          cfg_chan
);
  import pcg32_pkg::*;

  pcg_cmd_t    cmd;
  pcg_status_t status;

  pcg32_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_count  (in_chan.count),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcg32_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_chan.valid),
    .cfg_ready       (cfg_chan.ready),
    .cfg_stream_seed (cfg_chan.stream_seed),
    .cmd             (cmd),
    .status          (status),
    .out_value       (out_chan.value),
    .out_last        (out_chan.last)
  );

endmodule
